FILE: hdl/lda_gibbs_topic_sampler_unit_defines.svh
`ifndef LDA_GIBBS_TOPIC_SAMPLER_UNIT_DEFINES_SVH
`define LDA_GIBBS_TOPIC_SAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define LGS_ASSERT_IMPL(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("implication check failed");

// Next-cycle implication.
`define LGS_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

FILE: hdl/lgs_pkg.sv
`timescale 1ns / 1ps

package lgs_pkg;

   localparam int MAX_TOPICS = 64;
   localparam int MAX_DOCS   = 1024;
   localparam int MAX_VOCAB  = 4096;

   localparam int TOPIC_W = $clog2(MAX_TOPICS);
   localparam int DOC_W   = $clog2(MAX_DOCS);
   localparam int WORD_W  = $clog2(MAX_VOCAB);

   localparam int DT_AW    = DOC_W + TOPIC_W;
   localparam int TW_AW    = TOPIC_W + WORD_W;
   localparam int DT_DEPTH = MAX_DOCS * MAX_TOPICS;
   localparam int TW_DEPTH = MAX_TOPICS * MAX_VOCAB;

   localparam int CNT16_W = 16;
   localparam int CNT24_W = 24;

   localparam int K_CFG_W    = 7;
   localparam int V_CFG_W    = 13;
   localparam int PRIOR_W    = 16;
   localparam int FRAC_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int STATUS_W   = 2;

   localparam int A_W    = CNT16_W + 9;
   localparam int B_W    = CNT24_W + 9;
   localparam int D_W    = CNT24_W + 9;
   localparam int Q_W    = 32;
   localparam int REM_W  = D_W + 1;
   localparam int PROD_W = A_W + Q_W;
   localparam int ACC_W  = 64;
   localparam int VB_W   = V_CFG_W + PRIOR_W;

   localparam logic [CSR_IDX_W-1:0] REG_TOPICS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VOCAB  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BETA   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd2;

   localparam logic [1:0] TSEL_OLD = 2'd0;
   localparam logic [1:0] TSEL_K   = 2'd1;
   localparam logic [1:0] TSEL_NT  = 2'd2;

   typedef struct packed {
      logic                clr_en;
      logic                load_in;
      logic [1:0]          tsel;
      logic                wr_dec;
      logic                wr_inc;
      logic                w_start;
      logic                w_load;
      logic                div_init;
      logic                div_step;
      logic                mul;
      logic                acc;
      logic                thr_hi;
      logic                thr_lo;
      logic                thr_sum;
      logic                p_init;
      logic                p_cmp;
      logic                nt_old;
      logic                st_set;
      logic [STATUS_W-1:0] st_code;
      logic                res_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic range_err;
      logic mode;
      logic any_zero;
      logic can_add;
      logic div_sat;
      logic div_last;
      logic k_last;
      logic over_thr;
      logic rsp_busy;
   } stat_type;

endpackage

FILE: hdl/lgs_ram.sv
`timescale 1ns / 1ps

module lgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/lgs_datapath.sv
`timescale 1ns / 1ps

module lgs_datapath import lgs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_mode,
   input  logic [DOC_W-1:0]      in_doc_index,
   input  logic [WORD_W-1:0]     in_word_id,
   input  logic [TOPIC_W-1:0]    in_cur_topic,
   input  logic [FRAC_W-1:0]     in_random_fraction,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output stat_type              st,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [TOPIC_W-1:0]    rsp_topic,
   output logic                  rsp_changed,
   output logic [STATUS_W-1:0]   rsp_status
);

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] x,
                                                 input logic [ACC_W-1:0] y);
      logic [ACC_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[ACC_W] ? '1 : s[ACC_W-1:0];
   endfunction

   // configuration
   logic [K_CFG_W-1:0] topics_ff;
   logic [V_CFG_W-1:0] vocab_ff;
   logic [PRIOR_W-1:0] alpha_ff, beta_ff;
   logic [VB_W-1:0]    vb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         topics_ff <= K_CFG_W'(8);
         vocab_ff  <= V_CFG_W'(4096);
         alpha_ff  <= PRIOR_W'(128);
         beta_ff   <= PRIOR_W'(26);
      end else if (csr_we) begin
         case (csr_index)
            REG_TOPICS: topics_ff <= csr_wdata[K_CFG_W-1:0];
            REG_VOCAB:  vocab_ff  <= csr_wdata[V_CFG_W-1:0];
            REG_ALPHA:  alpha_ff  <= csr_wdata[PRIOR_W-1:0];
            REG_BETA:   beta_ff   <= csr_wdata[PRIOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      vb_ff <= vocab_ff * beta_ff;
   end

   logic [K_CFG_W-1:0] nk;
   logic [V_CFG_W-1:0] vlim;

   always_comb begin
      if (topics_ff == '0) begin
         nk = K_CFG_W'(1);
      end else if (topics_ff > K_CFG_W'(MAX_TOPICS)) begin
         nk = K_CFG_W'(MAX_TOPICS);
      end else begin
         nk = topics_ff;
      end
      vlim = (vocab_ff < V_CFG_W'(MAX_VOCAB)) ? vocab_ff : V_CFG_W'(MAX_VOCAB);
   end

   // token fields and sequencing registers
   logic                mode_ff;
   logic [DOC_W-1:0]    doc_ff;
   logic [WORD_W-1:0]   word_ff;
   logic [TOPIC_W-1:0]  old_ff, k_ff, nt_ff;
   logic [FRAC_W-1:0]   frac_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [TW_AW-1:0]    clr_ff;

   // count tables
   logic [TOPIC_W-1:0] topic_sel;
   logic [DT_AW-1:0]   dt_addr;
   logic [TW_AW-1:0]   tw_addr;
   logic [TOPIC_W-1:0] tt_addr;
   logic [DOC_W-1:0]   dn_addr;
   logic               cnt_we;
   logic [CNT16_W-1:0] dt_rd, dn_rd, dt_wd, dn_wd;
   logic [CNT24_W-1:0] tw_rd, tt_rd, tw_wd, tt_wd;

   always_comb begin
      case (cmd.tsel)
         TSEL_OLD: topic_sel = old_ff;
         TSEL_K:   topic_sel = k_ff;
         TSEL_NT:  topic_sel = nt_ff;
         default:  topic_sel = old_ff;
      endcase
      if (cmd.clr_en) begin
         dt_addr = clr_ff[DT_AW-1:0];
         tw_addr = clr_ff;
         tt_addr = clr_ff[TOPIC_W-1:0];
         dn_addr = clr_ff[DOC_W-1:0];
         dt_wd   = '0;
         tw_wd   = '0;
         tt_wd   = '0;
         dn_wd   = '0;
      end else begin
         dt_addr = {doc_ff, topic_sel};
         tw_addr = {topic_sel, word_ff};
         tt_addr = topic_sel;
         dn_addr = doc_ff;
         if (cmd.wr_dec) begin
            dt_wd = dt_rd - 1'b1;
            tw_wd = tw_rd - 1'b1;
            tt_wd = tt_rd - 1'b1;
            dn_wd = dn_rd - 1'b1;
         end else begin
            dt_wd = dt_rd + 1'b1;
            tw_wd = tw_rd + 1'b1;
            tt_wd = tt_rd + 1'b1;
            dn_wd = dn_rd + 1'b1;
         end
      end
      cnt_we = cmd.clr_en | cmd.wr_dec | cmd.wr_inc;
   end

   lgs_ram #(.WIDTH(CNT16_W), .DEPTH(DT_DEPTH)) u_doc_topic (
      .clock(clock), .we(cnt_we), .waddr(dt_addr), .wdata(dt_wd),
      .raddr(dt_addr), .rdata(dt_rd));

   lgs_ram #(.WIDTH(CNT24_W), .DEPTH(TW_DEPTH)) u_topic_word (
      .clock(clock), .we(cnt_we), .waddr(tw_addr), .wdata(tw_wd),
      .raddr(tw_addr), .rdata(tw_rd));

   lgs_ram #(.WIDTH(CNT24_W), .DEPTH(MAX_TOPICS)) u_topic_total (
      .clock(clock), .we(cnt_we), .waddr(tt_addr), .wdata(tt_wd),
      .raddr(tt_addr), .rdata(tt_rd));

   lgs_ram #(.WIDTH(CNT16_W), .DEPTH(MAX_DOCS)) u_doc_total (
      .clock(clock), .we(cnt_we), .waddr(dn_addr), .wdata(dn_wd),
      .raddr(dn_addr), .rdata(dn_rd));

   // weight pass
   logic [A_W-1:0]    a_ff;
   logic [B_W-1:0]    b_ff;
   logic [D_W-1:0]    d_ff, d_sum;
   logic [REM_W-1:0]  rem_ff, rem_shift;
   logic [Q_W-1:0]    q_ff;
   logic [4:0]        cnt_ff;
   logic [7:0]        b_lo;
   logic              div_bit, div_sat;
   logic [PROD_W-1:0] prod_full;
   logic [ACC_W-1:0]  prod_ff, total_ff, run_ff, run_next, thr_ff, hi_ff, mprod;
   logic [FRAC_W-1:0] lo_ff, mult_a;
   logic [ACC_W-1:0]  wt_rd;

   assign d_sum   = D_W'({tt_rd, 8'h00}) + D_W'(vb_ff);
   assign div_sat = D_W'(b_ff[B_W-1:8]) >= d_ff;
   assign b_lo    = b_ff[7:0];
   // numerator is B << 24: only bits 31..24 of the low word are nonzero
   assign div_bit   = (cnt_ff[4:3] == 2'b11) ? b_lo[cnt_ff[2:0]] : 1'b0;
   assign rem_shift = {rem_ff[REM_W-2:0], div_bit};
   assign prod_full = a_ff * q_ff;
   assign mult_a    = cmd.thr_hi ? total_ff[ACC_W-1:FRAC_W] : total_ff[FRAC_W-1:0];
   assign mprod     = mult_a * frac_ff;
   assign run_next  = sat_add(run_ff, wt_rd);

   lgs_ram #(.WIDTH(ACC_W), .DEPTH(MAX_TOPICS)) u_weights (
      .clock(clock), .we(cmd.acc), .waddr(k_ff), .wdata(prod_ff),
      .raddr(k_ff), .rdata(wt_rd));

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         mode_ff   <= in_mode;
         doc_ff    <= in_doc_index;
         word_ff   <= in_word_id;
         old_ff    <= in_cur_topic;
         frac_ff   <= in_random_fraction;
         status_ff <= STATUS_OK;
      end else if (cmd.st_set) begin
         status_ff <= cmd.st_code;
      end
      if (cmd.nt_old) begin
         nt_ff <= old_ff;
      end else if (cmd.p_cmp) begin
         nt_ff <= k_ff;
      end
      if (cmd.w_start || cmd.p_init) begin
         k_ff <= '0;
      end else if (cmd.acc || cmd.p_cmp) begin
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.w_start) begin
         total_ff <= '0;
      end else if (cmd.acc) begin
         total_ff <= sat_add(total_ff, prod_ff);
      end
      if (cmd.w_load) begin
         a_ff <= A_W'({dt_rd, 8'h00}) + A_W'(alpha_ff);
         b_ff <= B_W'({tw_rd, 8'h00}) + B_W'(beta_ff);
         d_ff <= (d_sum == '0) ? D_W'(1) : d_sum;
      end
      if (cmd.div_init) begin
         rem_ff <= REM_W'(b_ff[B_W-1:8]);
         q_ff   <= div_sat ? '1 : '0;
         cnt_ff <= 5'd31;
      end else if (cmd.div_step) begin
         if (rem_shift >= REM_W'(d_ff)) begin
            rem_ff <= rem_shift - REM_W'(d_ff);
            q_ff   <= {q_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift;
            q_ff   <= {q_ff[Q_W-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.mul) begin
         prod_ff <= ACC_W'(prod_full);
      end
      if (cmd.thr_hi) begin
         hi_ff <= mprod;
      end
      if (cmd.thr_lo) begin
         lo_ff <= mprod[ACC_W-1:FRAC_W];
      end
      if (cmd.thr_sum) begin
         thr_ff <= hi_ff + ACC_W'(lo_ff);
      end
      if (cmd.p_init) begin
         run_ff <= '0;
      end else if (cmd.p_cmp) begin
         run_ff <= run_next;
      end
   end

   // clear sweep and result register
   logic                rsp_valid_ff;
   logic [TOPIC_W-1:0]  rsp_topic_ff;
   logic                rsp_changed_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_en) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_topic_ff   <= nt_ff;
         rsp_changed_ff <= (nt_ff != old_ff);
         rsp_status_ff  <= status_ff;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_topic   = rsp_topic_ff;
   assign rsp_changed = rsp_changed_ff;
   assign rsp_status  = rsp_status_ff;

   always_comb begin
      st.clr_last  = &clr_ff;
      st.range_err = ((DOC_W+1)'(doc_ff) >= (DOC_W+1)'(MAX_DOCS)) ||
                     (V_CFG_W'(word_ff) >= vlim) ||
                     (K_CFG_W'(old_ff) >= nk);
      st.mode      = mode_ff;
      st.any_zero  = (dt_rd == '0) || (tw_rd == '0) || (tt_rd == '0) || (dn_rd == '0);
      st.can_add   = (dt_rd != '1) && (tw_rd != '1) && (tt_rd != '1) && (dn_rd != '1);
      st.div_sat   = div_sat;
      st.div_last  = (cnt_ff == '0);
      st.k_last    = (K_CFG_W'(k_ff) == nk - 1'b1);
      st.over_thr  = (run_next > thr_ff);
      st.rsp_busy  = rsp_valid_ff && !rsp_tready;
   end

endmodule

FILE: hdl/lgs_controller.sv
`timescale 1ns / 1ps
`include "lda_gibbs_topic_sampler_unit_defines.svh"

module lgs_controller import lgs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type st,
   output cmd_type  cmd
);

   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_CHECK  = 5'd2;
   localparam logic [4:0] S_DEC_RD = 5'd3;
   localparam logic [4:0] S_DEC_EV = 5'd4;
   localparam logic [4:0] S_W_RD   = 5'd5;
   localparam logic [4:0] S_W_LD   = 5'd6;
   localparam logic [4:0] S_W_PRE  = 5'd7;
   localparam logic [4:0] S_W_DIV  = 5'd8;
   localparam logic [4:0] S_W_MUL  = 5'd9;
   localparam logic [4:0] S_W_ACC  = 5'd10;
   localparam logic [4:0] S_T_HI   = 5'd11;
   localparam logic [4:0] S_T_LO   = 5'd12;
   localparam logic [4:0] S_T_SUM  = 5'd13;
   localparam logic [4:0] S_P_RD   = 5'd14;
   localparam logic [4:0] S_P_CMP  = 5'd15;
   localparam logic [4:0] S_A_RD   = 5'd16;
   localparam logic [4:0] S_A_EV   = 5'd17;
   localparam logic [4:0] S_RESULT = 5'd18;

   logic [4:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.tsel   = TSEL_OLD;
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (st.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.nt_old = 1'b1;
            if (st.range_err) begin
               cmd.st_set  = 1'b1;
               cmd.st_code = STATUS_RANGE;
               state_in    = S_RESULT;
            end else if (!st.mode) begin
               state_in = S_A_RD;
            end else begin
               state_in = S_DEC_RD;
            end
         end
         S_DEC_RD: state_in = S_DEC_EV;
         S_DEC_EV: begin
            if (st.any_zero) begin
               cmd.st_set  = 1'b1;
               cmd.st_code = STATUS_UNDER;
               state_in    = S_RESULT;
            end else begin
               cmd.wr_dec  = 1'b1;
               cmd.w_start = 1'b1;
               state_in    = S_W_RD;
            end
         end
         S_W_RD: begin
            cmd.tsel = TSEL_K;
            state_in = S_W_LD;
         end
         S_W_LD: begin
            cmd.tsel   = TSEL_K;
            cmd.w_load = 1'b1;
            state_in   = S_W_PRE;
         end
         S_W_PRE: begin
            cmd.div_init = 1'b1;
            state_in     = st.div_sat ? S_W_MUL : S_W_DIV;
         end
         S_W_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) state_in = S_W_MUL;
         end
         S_W_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_W_ACC;
         end
         S_W_ACC: begin
            cmd.acc  = 1'b1;
            state_in = st.k_last ? S_T_HI : S_W_RD;
         end
         S_T_HI: begin
            cmd.thr_hi = 1'b1;
            state_in   = S_T_LO;
         end
         S_T_LO: begin
            cmd.thr_lo = 1'b1;
            state_in   = S_T_SUM;
         end
         S_T_SUM: begin
            cmd.thr_sum = 1'b1;
            cmd.p_init  = 1'b1;
            state_in    = S_P_RD;
         end
         S_P_RD: state_in = S_P_CMP;
         S_P_CMP: begin
            cmd.p_cmp = 1'b1;
            // no topic above threshold leaves the last active one picked
            state_in  = (st.over_thr || st.k_last) ? S_A_RD : S_P_RD;
         end
         S_A_RD: begin
            cmd.tsel = TSEL_NT;
            state_in = S_A_EV;
         end
         S_A_EV: begin
            cmd.tsel = TSEL_NT;
            if (st.can_add) begin
               cmd.wr_inc = 1'b1;
               state_in   = S_RESULT;
            end else if (!st.mode) begin
               cmd.st_set  = 1'b1;
               cmd.st_code = STATUS_UNDER;
               state_in    = S_RESULT;
            end else begin
               // picked topic full: fall back to the old one, which has room
               cmd.nt_old = 1'b1;
               state_in   = S_A_RD;
            end
         end
         S_RESULT: begin
            if (!st.rsp_busy) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   `LGS_ASSERT_IMPL(a_dec_nonzero, cmd.wr_dec, !st.any_zero)
   `LGS_ASSERT_IMPL(a_inc_room, cmd.wr_inc, st.can_add)
   `LGS_ASSERT_NEXT(a_result_once, cmd.res_load, !cmd.res_load && req_tready)
   `LGS_ASSERT_IMPL(a_no_write_on_accept, cmd.load_in, !(cmd.wr_dec || cmd.wr_inc || cmd.clr_en))

endmodule

FILE: hdl/lda_gibbs_topic_sampler_unit.sv
`timescale 1ns / 1ps
// Channel | Dir | Transfer when        | Contents
// req_    | in  | req_tvalid&tready    | tuser: mode; tdata: doc, word, old topic, fraction
// rsp_    | out | rsp_tvalid&tready    | tdata: new topic, changed, status
// csr_    | in  | csr_we               | index 0..3, write data 16 bits
//
// Mode 0 or an error skips the weight and pick passes. A resample takes longer
// with more active topics K, and less when a divide saturates and skips the divider:
// the bit-serial divider (32 steps per topic) of the weight pass dominates, plus a
// read and a compare step per topic visited in the pick pass.
// After reset a clearing sweep over 2^18 entries (the topic-word table depth)
// zeroes all count tables; no item is taken meanwhile, config writes are.
// A waiting result does not block the next transfer in; it only holds the
// sampler at its final step until rsp_tready.

module lda_gibbs_topic_sampler_unit import lgs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // doc_index[9:0], word_id[21:10], token_topic[27:22], random_fraction[59:28]
   input  logic [63:0]           req_tdata,
   // mode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_topic[5:0], changed[6], status[8:7]
   output logic [15:0]           rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type             cmd;
   stat_type            st;
   logic [TOPIC_W-1:0]  topic_out;
   logic                changed;
   logic [STATUS_W-1:0] status;

   lgs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .st        (st),
      .cmd       (cmd)
   );

   lgs_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .in_mode           (req_tuser),
      .in_doc_index      (req_tdata[9:0]),
      .in_word_id        (req_tdata[21:10]),
      .in_cur_topic      (req_tdata[27:22]),
      .in_random_fraction(req_tdata[59:28]),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .st                (st),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_topic         (topic_out),
      .rsp_changed       (changed),
      .rsp_status        (status)
   );

   assign rsp_tdata = {7'b0, status, changed, topic_out};

endmodule
